// ===== design/heap_sort_records_by_key_defines.svh =====
// assertion macros used by the heap sort datapath (hsr_dp)
`ifndef HEAP_SORT_RECORDS_BY_KEY_DEFINES_SVH
`define HEAP_SORT_RECORDS_BY_KEY_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked on i_clk, off while i_rst_n is low
`define HSR_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication, checked on i_clk, off while i_rst_n is low
`define HSR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define HSR_ASSERT_IMPL(label, ante, cons, msg)
`define HSR_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== design/hsr_pkg.sv =====
// shared types for the heap sort block: record, fsm state, command and status
`timescale 1ns / 1ps
`default_nettype none

package hsr_pkg;

    typedef struct packed {
        logic signed [31:0] key;
        logic [15:0]        tag;
    } t_rec;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_PREP,
        ST_BLD_RD,
        ST_BLD_LD,
        ST_SIFT_RD,
        ST_SIFT_CMP,
        ST_EXT_RD,
        ST_EXT_WR,
        ST_EMIT_RD,
        ST_EMIT_WAIT
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic prep;
        logic bld_rd;
        logic bld_ld;
        logic sift_rd;
        logic sift_cmp;
        logic ext_rd;
        logic ext_wr;
        logic emit_rd;
        logic emit_ld;
    } t_cmd;

    typedef struct packed {
        logic acc_last;
        logic half_zero;
        logic move;
        logic bld_zero;
        logic len_gt1;
        logic emit_last;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

// ===== design/hsr_ctrl.sv =====
// sequencer for load, heap build, extraction and emission
`timescale 1ns / 1ps
`default_nettype none

module hsr_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire hsr_pkg::t_stat i_stat,
    output hsr_pkg::t_cmd      o_cmd
);

    hsr_pkg::t_state r_state;
    hsr_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hsr_pkg::ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            hsr_pkg::ST_LOAD: begin
                if (i_stat.acc_last) n_state = hsr_pkg::ST_PREP;
            end
            hsr_pkg::ST_PREP: begin
                n_state = i_stat.half_zero ? hsr_pkg::ST_EMIT_RD : hsr_pkg::ST_BLD_RD;
            end
            hsr_pkg::ST_BLD_RD:  n_state = hsr_pkg::ST_BLD_LD;
            hsr_pkg::ST_BLD_LD:  n_state = hsr_pkg::ST_SIFT_RD;
            hsr_pkg::ST_SIFT_RD: n_state = hsr_pkg::ST_SIFT_CMP;
            hsr_pkg::ST_SIFT_CMP: begin
                if (i_stat.move) begin
                    n_state = hsr_pkg::ST_SIFT_RD;
                end else if (!i_stat.bld_zero) begin
                    n_state = hsr_pkg::ST_BLD_RD;
                end else if (i_stat.len_gt1) begin
                    n_state = hsr_pkg::ST_EXT_RD;
                end else begin
                    n_state = hsr_pkg::ST_EMIT_RD;
                end
            end
            hsr_pkg::ST_EXT_RD:  n_state = hsr_pkg::ST_EXT_WR;
            hsr_pkg::ST_EXT_WR:  n_state = hsr_pkg::ST_SIFT_RD;
            hsr_pkg::ST_EMIT_RD: n_state = hsr_pkg::ST_EMIT_WAIT;
            hsr_pkg::ST_EMIT_WAIT: begin
                if (i_stat.out_free) begin
                    n_state = i_stat.emit_last ? hsr_pkg::ST_LOAD : hsr_pkg::ST_EMIT_RD;
                end
            end
            default: n_state = hsr_pkg::ST_LOAD;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            hsr_pkg::ST_LOAD:      o_cmd.in_ready = 1'b1;
            hsr_pkg::ST_PREP:      o_cmd.prep     = 1'b1;
            hsr_pkg::ST_BLD_RD:    o_cmd.bld_rd   = 1'b1;
            hsr_pkg::ST_BLD_LD:    o_cmd.bld_ld   = 1'b1;
            hsr_pkg::ST_SIFT_RD:   o_cmd.sift_rd  = 1'b1;
            hsr_pkg::ST_SIFT_CMP:  o_cmd.sift_cmp = 1'b1;
            hsr_pkg::ST_EXT_RD:    o_cmd.ext_rd   = 1'b1;
            hsr_pkg::ST_EXT_WR:    o_cmd.ext_wr   = 1'b1;
            hsr_pkg::ST_EMIT_RD:   o_cmd.emit_rd  = 1'b1;
            hsr_pkg::ST_EMIT_WAIT: o_cmd.emit_ld  = i_stat.out_free;
            default:               o_cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== design/hsr_dp.sv =====
// record store, sift compare unit, counters and output register
`timescale 1ns / 1ps
`default_nettype none

`include "heap_sort_records_by_key_defines.svh"

module hsr_dp #(
    parameter int MAX_RECORDS = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire hsr_pkg::t_cmd      i_cmd,
    output hsr_pkg::t_stat          o_stat,
    input  wire logic               i_in_valid,
    input  wire logic signed [31:0] i_record_key,
    input  wire logic [15:0]        i_record_tag,
    input  wire logic               i_last_record,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic signed [31:0]      o_sorted_key,
    output logic [15:0]             o_sorted_tag,
    output logic                    o_end_of_set,
    output logic [31:0]             o_swap_total,
    output logic                    o_overflow
);

    localparam int AW = $clog2(MAX_RECORDS);
    localparam int CW = $clog2(MAX_RECORDS + 1);
    localparam int KW = AW + 2;

    hsr_pkg::t_rec mem [MAX_RECORDS];

    logic [CW-1:0]      r_count;
    logic               r_drop;
    logic [CW-1:0]      r_len;
    logic [CW-2:0]      r_bld;
    logic [AW-1:0]      r_pos;
    logic [AW-1:0]      r_k;
    logic [31:0]        r_swap;
    hsr_pkg::t_rec      r_cur;
    hsr_pkg::t_rec      r_rd_a;
    hsr_pkg::t_rec      r_rd_b;
    logic               r_out_valid;
    logic signed [31:0] r_out_key;
    logic [15:0]        r_out_tag;
    logic               r_out_end;
    logic [31:0]        r_out_swap;
    logic               r_out_ovf;

    logic               accept;
    logic               room;
    logic [KW-1:0]      lc;
    logic [KW-1:0]      rc;
    logic               lc_in;
    logic               rc_in;
    logic               sel_l;
    logic               sel_r;
    logic signed [31:0] top_key;
    logic               move;
    hsr_pkg::t_rec      win;
    logic [AW-1:0]      top_idx;
    logic               swap_inc;
    logic               emit_last;
    logic               out_free;
    logic               rd_en_a;
    logic               rd_en_b;
    logic [AW-1:0]      addr_a;
    logic [AW-1:0]      addr_b;
    logic               we;
    logic [AW-1:0]      wa;
    hsr_pkg::t_rec      wd;

    assign accept = i_cmd.in_ready & i_in_valid;
    assign room   = r_count < CW'(MAX_RECORDS);

    // children of the sift position
    assign lc    = {1'b0, r_pos, 1'b1};
    assign rc    = lc + KW'(1);
    assign lc_in = lc < KW'(r_len);
    assign rc_in = rc < KW'(r_len);

    // left first, then right against the winner, strict greater only
    assign sel_l   = lc_in && (r_rd_a.key > r_cur.key);
    assign top_key = sel_l ? r_rd_a.key : r_cur.key;
    assign sel_r   = rc_in && (r_rd_b.key > top_key);
    assign move    = sel_l | sel_r;
    assign win     = sel_r ? r_rd_b : r_rd_a;
    assign top_idx = sel_r ? rc[AW-1:0] : lc[AW-1:0];

    assign swap_inc  = (i_cmd.sift_cmp & move) | i_cmd.ext_wr;
    assign emit_last = (CW'(r_k) + CW'(1)) == r_count;
    assign out_free  = !r_out_valid || i_out_ready;

    always_comb begin
        rd_en_a = i_cmd.bld_rd | i_cmd.sift_rd | i_cmd.ext_rd | i_cmd.emit_rd;
        rd_en_b = i_cmd.sift_rd | i_cmd.ext_rd;
        addr_a  = '0;
        addr_b  = '0;
        if (i_cmd.bld_rd)  addr_a = AW'(r_bld - 1'b1);
        if (i_cmd.sift_rd) addr_a = lc[AW-1:0];
        if (i_cmd.emit_rd) addr_a = r_k;
        if (i_cmd.sift_rd) addr_b = rc[AW-1:0];
        if (i_cmd.ext_rd)  addr_b = AW'(r_len - 1'b1);
    end

    // the sifted record stays in r_cur; a moving child is written up to the sift position, r_cur once it settles
    always_comb begin
        we = 1'b0;
        wa = '0;
        wd = '0;
        if (accept && room) begin
            we     = 1'b1;
            wa     = r_count[AW-1:0];
            wd.key = i_record_key;
            wd.tag = i_record_tag;
        end else if (i_cmd.sift_cmp) begin
            we = 1'b1;
            wa = r_pos;
            wd = move ? win : r_cur;
        end else if (i_cmd.ext_wr) begin
            we = 1'b1;
            wa = AW'(r_len - 1'b1);
            wd = r_rd_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) mem[wa] <= wd;
        if (rd_en_a) r_rd_a <= mem[addr_a];
        if (rd_en_b) r_rd_b <= mem[addr_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_drop  <= 1'b0;
            r_len   <= '0;
            r_bld   <= '0;
            r_pos   <= '0;
            r_k     <= '0;
            r_swap  <= '0;
        end else begin
            if (accept) begin
                if (room) r_count <= r_count + CW'(1);
                else      r_drop  <= 1'b1;
            end
            if (i_cmd.prep) begin
                r_len <= r_count;
                r_bld <= r_count[CW-1:1];
                r_k   <= '0;
            end
            if (i_cmd.bld_ld) begin
                r_pos <= AW'(r_bld - 1'b1);
                r_bld <= r_bld - 1'b1;
            end
            if (i_cmd.sift_cmp && move) r_pos <= top_idx;
            if (i_cmd.ext_wr) begin
                r_pos <= '0;
                r_len <= r_len - CW'(1);
            end
            if (swap_inc && (r_swap != '1)) r_swap <= r_swap + 32'd1;
            if (i_cmd.emit_ld) begin
                r_k <= r_k + AW'(1);
                if (emit_last) begin
                    r_count <= '0;
                    r_drop  <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.bld_ld) r_cur <= r_rd_a;
        if (i_cmd.ext_wr) r_cur <= r_rd_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_ld) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_ld) begin
            r_out_key  <= r_rd_a.key;
            r_out_tag  <= r_rd_a.tag;
            r_out_end  <= emit_last;
            r_out_swap <= r_swap;
            r_out_ovf  <= r_drop;
        end
    end

    assign o_stat.acc_last  = accept & i_last_record;
    assign o_stat.half_zero = r_count[CW-1:1] == '0;
    assign o_stat.move      = move;
    assign o_stat.bld_zero  = r_bld == '0;
    assign o_stat.len_gt1   = r_len > CW'(1);
    assign o_stat.emit_last = emit_last;
    assign o_stat.out_free  = out_free;

    assign o_out_valid  = r_out_valid;
    assign o_sorted_key = r_out_key;
    assign o_sorted_tag = r_out_tag;
    assign o_end_of_set = r_out_end;
    assign o_swap_total = r_out_swap;
    assign o_overflow   = r_out_ovf;

    `HSR_ASSERT_IMPL(a_count_cap, 1'b1, r_count <= CW'(MAX_RECORDS), "record count over capacity")
    `HSR_ASSERT_NEXT(a_swap_mono, 1'b1, r_swap >= $past(r_swap), "swap total went backward")
    `HSR_ASSERT_IMPL(a_emit_free, i_cmd.emit_ld, !r_out_valid || i_out_ready, "output overwritten")
    `HSR_ASSERT_IMPL(a_pos_heap, i_cmd.sift_cmp, CW'(r_pos) < r_len, "sift position outside heap")

endmodule

`default_nettype wire

// ===== design/heap_sort_records_by_key.sv =====
// top level of the heap sort block: controller plus datapath
// loading takes one cycle per record beat, input is held off from the last beat to burst end
// sort steps for n records: setup, a store read and a load per build node, a store read and a write per
// extraction, and for each sift level one registered read of both children and one compare/write step
// emission: per sorted record, one registered store read then the output load when the output is free
// reset (synchronous, active low) clears control, counts and swap total; the store is not cleared
`timescale 1ns / 1ps
`default_nettype none

module heap_sort_records_by_key #(
    parameter int MAX_RECORDS = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // input records
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic signed [31:0] i_record_key,
    input  wire logic [15:0]        i_record_tag,
    input  wire logic               i_last_record,
    // sorted records
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic signed [31:0]      o_sorted_key,
    output logic [15:0]             o_sorted_tag,
    output logic                    o_end_of_set,
    output logic [31:0]             o_swap_total,
    output logic                    o_overflow
);

    // command and status between the sequencer and the datapath
    hsr_pkg::t_cmd  cmd;
    hsr_pkg::t_stat stat;

    // sequencer: load, bottom-up build, root extraction, emission
    hsr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // record store with two read ports, sift compare, swap counter, output beat register
    hsr_dp #(
        .MAX_RECORDS (MAX_RECORDS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_in_valid    (i_in_valid),
        .i_record_key  (i_record_key),
        .i_record_tag  (i_record_tag),
        .i_last_record (i_last_record),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_sorted_key  (o_sorted_key),
        .o_sorted_tag  (o_sorted_tag),
        .o_end_of_set  (o_end_of_set),
        .o_swap_total  (o_swap_total),
        .o_overflow    (o_overflow)
    );

    // input beats are taken only while the sequencer is in the load phase
    assign o_in_ready = cmd.in_ready;

endmodule

`default_nettype wire

// ===== bench/tb_heap_sort_records_by_key.sv =====
// self-checking testbench for the heap sort block: directed and random record sets against a heap sort predictor
`timescale 1ns / 1ps

module tb_heap_sort_records_by_key;

    localparam int MAX_RECORDS = 64;
    localparam int STIM_RECORDS = 450;
    localparam int CYCLE_LIMIT = 400000;
    // the long receiver hold starts while the full-capacity set is loading
    localparam int HOLD_AT_BEAT = 30;
    localparam int HOLD_CYCLES = 3000;
    localparam int MAX_REPORTS = 10;
    localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] KEY_MAX = 32'sh7FFF_FFFF;

    typedef enum int {
        KEYS_WIDE,
        KEYS_CLUSTERED,
        KEYS_EXTREME,
        KEYS_RISING,
        KEYS_FALLING
    } t_key_pattern;

    typedef struct {
        logic signed [31:0] key;
        logic [15:0]        tag;
        logic               last;
        bit                 drain_first;  // hold this beat back until all results are out
    } t_record_beat;

    typedef struct {
        logic signed [31:0] key;
        logic [15:0]        tag;
        logic               end_of_set;
        logic [31:0]        swaps;
        logic               overflow;
    } t_sorted_beat;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_ready;
    logic signed [31:0]      i_record_key = '0;
    logic [15:0]             i_record_tag = '0;
    logic                    i_last_record = 1'b0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    logic signed [31:0]      o_sorted_key;
    logic [15:0]             o_sorted_tag;
    logic                    o_end_of_set;
    logic [31:0]             o_swap_total;
    logic                    o_overflow;

    heap_sort_records_by_key #(
        .MAX_RECORDS(MAX_RECORDS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_record_key (i_record_key),
        .i_record_tag (i_record_tag),
        .i_last_record(i_last_record),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_sorted_key (o_sorted_key),
        .o_sorted_tag (o_sorted_tag),
        .o_end_of_set (o_end_of_set),
        .o_swap_total (o_swap_total),
        .o_overflow   (o_overflow)
    );

    // predictor state: record store, fill level, swap total, dropped flag
    hsr_pkg::t_rec held[MAX_RECORDS];
    int          held_count = 0;
    logic [31:0] swap_count = '0;
    logic        set_dropped = 1'b0;

    t_record_beat offered_records[$];
    t_sorted_beat sorted_due[$];

    int  errors = 0;
    int  mismatches = 0;
    int  in_beats = 0;
    bit  in_taken = 1'b0;
    int  cycles = 0;

    // sender and receiver pacing
    int  in_gap = 0;
    int  in_calm = 0;
    int  out_gap = 0;
    int  out_calm = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------
    // predictor: exchange two held records, counting the swap with saturation
    // ------------------------------------------------------------------
    function automatic void swap_held(int p, int q);
        hsr_pkg::t_rec r;
        r = held[p];
        held[p] = held[q];
        held[q] = r;
        if (swap_count != 32'hFFFF_FFFF) begin
            swap_count++;
        end
    endfunction

    // sift pos down a max-heap of len entries; left child first, right child
    // only wins on a strictly larger key than the current winner
    function automatic void sift_down_held(int len, int pos);
        int top;
        int lc;
        int rc;
        while (1) begin
            top = pos;
            lc = 2 * pos + 1;
            rc = 2 * pos + 2;
            if (lc < len && $signed(held[lc].key) > $signed(held[top].key)) begin
                top = lc;
            end
            if (rc < len && $signed(held[rc].key) > $signed(held[top].key)) begin
                top = rc;
            end
            if (top == pos) begin
                break;
            end
            swap_held(pos, top);
            pos = top;
        end
    endfunction

    // store one accepted record; on the last mark sort the set and queue the burst
    function automatic void load_and_sort(logic signed [31:0] key, logic [15:0] tag,
                                          logic last);
        int n;
        t_sorted_beat b;
        if (held_count < MAX_RECORDS) begin
            held[held_count] = '{key: key, tag: tag};
            held_count++;
        end else begin
            // store full: record dropped, last mark still ends the set
            set_dropped = 1'b1;
        end
        if (last) begin
            n = held_count;
            for (int i = n / 2; i > 0; i--) begin
                sift_down_held(n, i - 1);
            end
            for (int i = n; i > 1; i--) begin
                swap_held(0, i - 1);
                sift_down_held(i - 1, 0);
            end
            for (int k = 0; k < n; k++) begin
                b.key = held[k].key;
                b.tag = held[k].tag;
                b.end_of_set = (k == n - 1);
                b.swaps = swap_count;
                b.overflow = set_dropped;
                sorted_due.push_back(b);
            end
            held_count = 0;
            set_dropped = 1'b0;
        end
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    // mostly back to back, some short gaps, a few long ones
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    task automatic add_record(logic signed [31:0] key, logic [15:0] tag, logic last,
                              bit drain_first);
        t_record_beat r;
        r.key = key;
        r.tag = tag;
        r.last = last;
        r.drain_first = drain_first;
        offered_records.push_back(r);
    endtask

    task automatic add_set(int n, t_key_pattern pattern, bit drain_first);
        logic signed [31:0] key;
        for (int i = 0; i < n; i++) begin
            case (pattern)
                KEYS_WIDE: key = $urandom;
                KEYS_CLUSTERED: key = $urandom_range(0, 6) - 3;  // many equal keys
                KEYS_EXTREME: begin
                    case ($urandom_range(0, 3))
                        0: key = KEY_MIN;
                        1: key = KEY_MAX;
                        2: key = 0;
                        default: key = -1;
                    endcase
                end
                KEYS_RISING: key = i * 1000 - 30000;
                default: key = 30000 - i * 1000;
            endcase
            add_record(key, 16'($urandom), i == n - 1, drain_first && i == 0);
        end
    endtask

    // ------------------------------------------------------------------
    // stimulus plan, reset and end of run
    // ------------------------------------------------------------------
    initial begin
        int r;
        int n;

        // single record: nothing to sort, no swaps
        add_record(KEY_MAX, 16'hFFFF, 1'b1, 1'b0);
        // two records, already ascending and then descending, at the key extremes
        add_record(KEY_MIN, 16'h0000, 1'b0, 1'b0);
        add_record(KEY_MAX, 16'hFFFF, 1'b1, 1'b0);
        add_record(KEY_MAX, 16'h0001, 1'b0, 1'b0);
        add_record(KEY_MIN, 16'h0002, 1'b1, 1'b0);
        // equal keys, ordering decided by the compare order only
        for (int i = 0; i < 5; i++) begin
            add_record(32'sd7, 16'h0010 + 16'(i), i == 4, 1'b0);
        end
        // sign boundary mix
        add_record(-32'sd1, 16'hAAAA, 1'b0, 1'b0);
        add_record(32'sd0, 16'h5555, 1'b0, 1'b0);
        add_record(32'sd1, 16'h8000, 1'b0, 1'b0);
        add_record(KEY_MIN, 16'h0001, 1'b0, 1'b0);
        add_record(KEY_MAX, 16'h7FFF, 1'b0, 1'b0);
        add_record(-32'sd2, 16'h1234, 1'b0, 1'b0);
        add_record(32'sd2, 16'hFEDC, 1'b1, 1'b0);
        // sender waits for the previous burst to drain first
        add_record(32'sd100, 16'h00FF, 1'b0, 1'b1);
        add_record(-32'sd100, 16'hFF00, 1'b0, 1'b0);
        add_record(32'sd100, 16'h0F0F, 1'b1, 1'b0);

        // full store, then overflow with the last record itself dropped
        add_set(MAX_RECORDS, KEYS_WIDE, 1'b0);
        add_set(MAX_RECORDS + 3, KEYS_CLUSTERED, 1'b0);
        add_set(MAX_RECORDS + 1, KEYS_EXTREME, 1'b1);

        // random sets, mostly small, a few at or beyond capacity
        while (offered_records.size() < STIM_RECORDS) begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                n = $urandom_range(1, 8);
            end else if (r < 85) begin
                n = $urandom_range(9, 24);
            end else if (r < 95) begin
                n = $urandom_range(25, MAX_RECORDS);
            end else begin
                n = $urandom_range(MAX_RECORDS + 1, MAX_RECORDS + 8);
            end
            add_set(n, t_key_pattern'($urandom_range(0, 4)), $urandom_range(0, 9) == 0);
        end

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (offered_records.size() != 0 || i_in_valid) begin
            @(posedge i_clk);
        end
        while (sorted_due.size() != 0) begin
            @(posedge i_clk);
        end
        // idle tail: any stray beat here counts as unexpected
        repeat (40) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASS heap_sort_records_by_key");
        end else begin
            $display("FAIL heap_sort_records_by_key");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL heap_sort_records_by_key");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // record driver: changes inputs on the falling edge only
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        t_record_beat r;
        if (i_rst_n && !(i_in_valid && !in_taken)) begin
            // either idle or the current beat was just taken
            if (in_calm > 0) begin
                in_calm--;
            end else if ($urandom_range(0, 99) == 0) begin
                in_calm = $urandom_range(40, 150);
            end
            if (in_gap > 0) begin
                in_gap--;
                i_in_valid <= 1'b0;
            end else if (offered_records.size() != 0 &&
                         !(offered_records[0].drain_first && sorted_due.size() != 0)) begin
                r = offered_records.pop_front();
                i_in_valid <= 1'b1;
                i_record_key <= r.key;
                i_record_tag <= r.tag;
                i_last_record <= r.last;
                in_gap = (in_calm > 0) ? 0 : idle_gap();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // result receiver: random stalls, stall-free stretches, one long hold
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (!hold_done && in_beats >= HOLD_AT_BEAT) begin
                // sender keeps offering while results back up and input stalls
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                i_out_ready <= 1'b0;
            end else if (out_calm > 0) begin
                out_calm--;
                i_out_ready <= 1'b1;
            end else if (out_gap > 0) begin
                out_gap--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                if ($urandom_range(0, 99) < 3) begin
                    out_calm = $urandom_range(40, 150);
                end else begin
                    out_gap = idle_gap();
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: sample both handshakes on the rising edge
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_sorted_beat want;
        if (!i_rst_n) begin
            in_taken = 1'b0;
        end else begin
            in_taken = i_in_valid && o_in_ready;
            if (in_taken) begin
                in_beats++;
                load_and_sort(i_record_key, i_record_tag, i_last_record);
            end
            if (o_out_valid && i_out_ready) begin
                if (sorted_due.size() == 0) begin
                    errors++;
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("unexpected sorted beat: key %0d tag %h eos %b swaps %0d ovf %b",
                                 o_sorted_key, o_sorted_tag, o_end_of_set, o_swap_total,
                                 o_overflow);
                    end
                end else begin
                    want = sorted_due.pop_front();
                    if (o_sorted_key !== want.key || o_sorted_tag !== want.tag ||
                        o_end_of_set !== want.end_of_set || o_swap_total !== want.swaps ||
                        o_overflow !== want.overflow) begin
                        errors++;
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display("sorted beat mismatch at cycle %0d", cycles);
                            $display("  expected key %0d tag %h eos %b swaps %0d ovf %b",
                                     want.key, want.tag, want.end_of_set, want.swaps,
                                     want.overflow);
                            $display("  actual   key %0d tag %h eos %b swaps %0d ovf %b",
                                     o_sorted_key, o_sorted_tag, o_end_of_set, o_swap_total,
                                     o_overflow);
                        end
                    end
                end
            end
        end
    end

endmodule
